// ===== rtl/bss_pkg.sv =====
// Shared types and constants for the bubble sort and linear search block.
// Used by the controller, the datapath and the top level; depends on nothing.
package bss_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int WORD_W        = 32;
   localparam int INDEX_W       = 6;

   typedef struct packed {
      logic                     req_type;
      logic signed [WORD_W-1:0] value;
      logic                     last_element;
   } req_item_type;

   typedef struct packed {
      logic                     result_kind;
      logic signed [WORD_W-1:0] sorted_value;
      logic                     found;
      logic [INDEX_W-1:0]       found_index;
      logic                     last_of_run;
   } rsp_item_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic load;
      logic scan_init;
      logic scan_step;
      logic sort_init;
      logic pass_start;
      logic pass_first;
      logic pass_step;
      logic pass_end;
      logic emit_init;
      logic emit_step;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_search;
      logic is_last;
      logic scan_done;
      logic count_small;
      logic pair_last;
      logic top_le2;
      logic emit_done;
   } dp_stat_type;

endpackage

// ===== rtl/bss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bss_ctrl.sv =====
// Sequencing state machine: accepts words, steps the datapath through load,
// search scan, bubble passes and sorted output. Depends on bss_pkg.
module bss_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  bss_pkg::dp_stat_type stat,
   output bss_pkg::ctl_cmd_type cmd
);

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_DISPATCH   = 4'd1;
   localparam logic [3:0] S_SCAN       = 4'd2;
   localparam logic [3:0] S_SORT_INIT  = 4'd3;
   localparam logic [3:0] S_PASS_START = 4'd4;
   localparam logic [3:0] S_PASS_FIRST = 4'd5;
   localparam logic [3:0] S_PASS_STEP  = 4'd6;
   localparam logic [3:0] S_PASS_END   = 4'd7;
   localparam logic [3:0] S_EMIT_INIT  = 4'd8;
   localparam logic [3:0] S_EMIT       = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.is_search) begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end else begin
               cmd.load = 1'b1;
               state_in = stat.is_last ? S_SORT_INIT : S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               state_in = S_IDLE;
            end
         end
         S_SORT_INIT: begin
            cmd.sort_init = 1'b1;
            state_in      = stat.count_small ? S_EMIT_INIT : S_PASS_START;
         end
         S_PASS_START: begin
            cmd.pass_start = 1'b1;
            state_in       = S_PASS_FIRST;
         end
         S_PASS_FIRST: begin
            cmd.pass_first = 1'b1;
            state_in       = S_PASS_STEP;
         end
         S_PASS_STEP: begin
            cmd.pass_step = 1'b1;
            if (stat.pair_last) begin
               state_in = S_PASS_END;
            end
         end
         S_PASS_END: begin
            cmd.pass_end = 1'b1;
            state_in     = stat.top_le2 ? S_EMIT_INIT : S_PASS_START;
         end
         S_EMIT_INIT: begin
            cmd.emit_init = 1'b1;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit_step = 1'b1;
            if (stat.emit_done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_capture_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> busy)
      else $error("accepted word did not make the block busy");

   a_idle_no_work: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !(cmd.scan_step || cmd.pass_step || cmd.emit_step || cmd.load))
      else $error("datapath work commanded while idle");

   a_pass_order: assert property (@(posedge clock) disable iff (reset)
      cmd.pass_start |=> cmd.pass_first)
      else $error("bubble pass did not load its first element");

endmodule

// ===== rtl/bss_dp.sv =====
// Datapath: element store, batch count, scan and pass counters, carry
// register for the bubble pass, and the registered result word.
// Depends on bss_pkg and bss_ram.
module bss_dp #(
   parameter int DEPTH = bss_pkg::DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bss_pkg::req_item_type req_data,
   input  bss_pkg::ctl_cmd_type  cmd,
   output bss_pkg::dp_stat_type  stat,
   output logic                  rsp_strobe,
   output bss_pkg::rsp_item_type rsp_data
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int WW    = bss_pkg::WORD_W;
   localparam int IDX_W = bss_pkg::INDEX_W;

   bss_pkg::req_item_type item_ff, item_in;
   bss_pkg::rsp_item_type rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  closed_ff, closed_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic                  pend_ff, pend_in;
   logic [AW-1:0]         pidx_ff, pidx_in;
   logic [CW-1:0]         top_ff, top_in;
   logic [WW-1:0]         carry_ff, carry_in;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_wa, ram_ra;
   logic [WW-1:0] ram_wd, rd_data;

   logic [CW-1:0] eff_count, idx_p1, idx_p2, top_m1, cnt_m1;
   logic          space, hit, nomore, gt, pair_last, emit_last;

   assign eff_count = closed_ff ? '0 : count_ff;
   assign space     = (eff_count < CW'(DEPTH));
   assign idx_p1    = idx_ff + CW'(1);
   assign idx_p2    = idx_ff + CW'(2);
   assign top_m1    = top_ff - CW'(1);
   assign cnt_m1    = count_ff - CW'(1);
   assign hit       = pend_ff && (rd_data == $unsigned(item_ff.value));
   assign nomore    = (idx_ff >= count_ff);
   assign gt        = ($signed(carry_ff) > $signed(rd_data));
   assign pair_last = (idx_p2 == top_ff);
   assign emit_last = (pidx_ff == cnt_m1[AW-1:0]);

   assign stat.is_search   = item_ff.req_type;
   assign stat.is_last     = item_ff.last_element;
   assign stat.scan_done   = hit || nomore;
   assign stat.count_small = (count_ff < CW'(2));
   assign stat.pair_last   = pair_last;
   assign stat.top_le2     = (top_ff <= CW'(2));
   assign stat.emit_done   = pend_ff && emit_last;

   always_comb begin
      item_in      = item_ff;
      count_in     = count_ff;
      closed_in    = closed_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      top_in       = top_ff;
      carry_in     = carry_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_wa       = '0;
      ram_wd       = carry_ff;
      ram_re       = 1'b0;
      ram_ra       = '0;

      if (cmd.capture) begin
         item_in = req_data;
      end

      // a load after a sorted batch starts a new batch at index zero
      if (cmd.load) begin
         closed_in = 1'b0;
         if (space) begin
            ram_we   = 1'b1;
            ram_wa   = eff_count[AW-1:0];
            ram_wd   = $unsigned(item_ff.value);
            count_in = eff_count + CW'(1);
         end else begin
            count_in = eff_count;
         end
      end

      if (cmd.scan_init || cmd.emit_init) begin
         idx_in  = '0;
         pend_in = 1'b0;
      end
      if (cmd.emit_init) begin
         closed_in = 1'b1;
      end

      // scan: one read issued per cycle, compare the word read last cycle
      if (cmd.scan_step) begin
         if (hit || nomore) begin
            rsp_valid_in       = 1'b1;
            rsp_in.result_kind = 1'b1;
            rsp_in.sorted_value = '0;
            rsp_in.found       = hit;
            rsp_in.found_index = hit ? IDX_W'(pidx_ff) : '0;
            rsp_in.last_of_run = 1'b1;
            pend_in            = 1'b0;
         end else begin
            ram_re  = 1'b1;
            ram_ra  = idx_ff[AW-1:0];
            pend_in = 1'b1;
            pidx_in = idx_ff[AW-1:0];
            idx_in  = idx_p1;
         end
      end

      if (cmd.sort_init) begin
         top_in = count_ff;
      end

      if (cmd.pass_start) begin
         ram_re = 1'b1;
         ram_ra = '0;
         idx_in = '0;
      end

      if (cmd.pass_first) begin
         carry_in = rd_data;
         ram_re   = 1'b1;
         ram_ra   = AW'(1);
      end

      // carry the larger word up, drop the smaller one at index j
      if (cmd.pass_step) begin
         ram_we   = 1'b1;
         ram_wa   = idx_ff[AW-1:0];
         ram_wd   = gt ? rd_data : carry_ff;
         carry_in = gt ? carry_ff : rd_data;
         idx_in   = idx_p1;
         if (!pair_last) begin
            ram_re = 1'b1;
            ram_ra = idx_p2[AW-1:0];
         end
      end

      if (cmd.pass_end) begin
         ram_we = 1'b1;
         ram_wa = top_m1[AW-1:0];
         ram_wd = carry_ff;
         top_in = top_m1;
      end

      if (cmd.emit_step) begin
         if (pend_ff) begin
            rsp_valid_in        = 1'b1;
            rsp_in.result_kind  = 1'b0;
            rsp_in.sorted_value = $signed(rd_data);
            rsp_in.found        = 1'b0;
            rsp_in.found_index  = '0;
            rsp_in.last_of_run  = emit_last;
         end
         if (!nomore) begin
            ram_re  = 1'b1;
            ram_ra  = idx_ff[AW-1:0];
            pend_in = 1'b1;
            pidx_in = idx_ff[AW-1:0];
            idx_in  = idx_p1;
         end else begin
            pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         closed_ff    <= 1'b0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         closed_ff    <= closed_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      pidx_ff  <= pidx_in;
      carry_ff <= carry_in;
      rsp_ff   <= rsp_in;
   end

   bss_ram #(
      .WIDTH (WW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (rd_data)
   );

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("batch count exceeds store depth");

   a_rw_apart: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_wa != ram_ra))
      else $error("store read and written at the same index in one cycle");

   a_run_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last_of_run) |=> !rsp_valid_ff)
      else $error("result word follows the end of a run at once");

   a_pass_range: assert property (@(posedge clock) disable iff (reset)
      cmd.pass_step |-> ((top_ff >= CW'(2)) && (idx_p1 < top_ff)))
      else $error("bubble pass index outside the active range");

endmodule

// ===== rtl/bubble_sort_and_linear_search.sv =====
// Top level of the bubble sort and linear search block.
// Depends on bss_pkg, bss_ctrl, bss_dp (and bss_ram through bss_dp).
//
// A word is taken when start is high and busy is low; one word is worked on
// at a time. A load that is not marked last gives no result. A search scans
// the single read port of the store one entry per cycle and answers with
// one result word. A load marked last sorts the N stored entries with bubble
// passes over the same read port and then sends the N sorted words back
// to back, the last one marked. Results appear on rsp_data for one cycle
// under rsp_strobe and cannot be held off: the receiver must take every
// word as it comes.
module bubble_sort_and_linear_search #(
   parameter int DEPTH = bss_pkg::DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  bss_pkg::req_item_type req_data,
   output logic                  rsp_strobe,
   output bss_pkg::rsp_item_type rsp_data
);

   bss_pkg::ctl_cmd_type cmd;
   bss_pkg::dp_stat_type stat;

   bss_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   bss_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
